>>> src/hfr_pkg.sv
// hfr_pkg: shared types and constants for the heartbeat flood relay
// used by every module in src; depends on nothing

package hfr_pkg;

	// frame format
	localparam logic [7:0] MAGIC_VALUE = 8'hA7;
	localparam logic [7:0] FRAME_BYTES = 8'd22;
	localparam int KEY_W = 24;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 21;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT = 2'd2;

	// register reset values
	localparam logic [7:0] OWN_ID_RST = 8'd0;
	localparam logic [20:0] BEAT_PERIOD_RST = 21'd512;
	localparam logic [7:0] HOP_LIMIT_RST = 8'd4;

	// opcodes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// one relayed frame held in the queue
	typedef struct packed {
		logic [7:0]  origin;
		logic [7:0]  hops;
		logic [7:0]  spare;
		logic [15:0] sequence_num;
		logic [31:0] time_word;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
	} q_entry_t;

	// control to the seen ring
	typedef struct packed {
		logic             scan;
		logic             record;
		logic [KEY_W-1:0] key;
	} seen_req_t;

	// status from the seen ring
	typedef struct packed {
		logic done;
		logic hit;
	} seen_rsp_t;

	// status from the queue
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

>>> src/heartbeat_flood_relay.sv
// heartbeat_flood_relay: flooding relay with duplicate suppression and own heartbeat
// depends on hfr_pkg, hfr_seen, hfr_queue
//
// Input channel (in_valid/in_stall) carries either a received frame (opcode 0)
// or a tick with a send opportunity (opcode 1). Output channel
// (out_valid/out_stall) carries the frame sent on a tick, if any. A transfer
// happens on a rising edge with valid high and stall low.
// Configuration writes go over cfg_valid/cfg_ready (ready is always high):
// index 0 own id, 1 heartbeat period, 2 hop limit; other indexes are ignored.
// One item is handled at a time; in_stall is high while it is in progress.
// A received frame that passes the header filter scans the seen ring one row
// of eight keys per cycle and stops early on a match. A rejected frame or a
// tick goes back to idle from the decide state; a tick that sends from the
// queue passes through the pop state first (one memory read).
// Results land in an output register, so the next item is taken while a
// result waits. A tick that must send waits while that register is held by
// a stalled receiver. Reset clears the seen valid bits, queue pointers,
// sequence counter and heartbeat timer at once; no clearing pass is needed.

module heartbeat_flood_relay import hfr_pkg::*; #(
	parameter int SEEN_DEPTH = 256,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [7:0]            frame_length,
	input  logic [7:0]            magic_byte,
	input  logic [7:0]            origin_node,
	input  logic [7:0]            hop_count,
	input  logic [7:0]            spare_byte,
	input  logic [15:0]           sequence_req,
	input  logic [31:0]           time_word,
	input  logic [31:0]           pos_x,
	input  logic [31:0]           pos_y,
	input  logic [31:0]           pos_z,
	input  logic                  link_ok,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_magic,
	output logic [7:0]            out_origin,
	output logic [7:0]            out_hops,
	output logic [7:0]            out_spare,
	output logic [15:0]           out_sequence,
	output logic [31:0]           out_time,
	output logic [31:0]           out_pos_x,
	output logic [31:0]           out_pos_y,
	output logic [31:0]           out_pos_z,
	output logic                  out_is_own,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_POP = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  state_d;

	// configuration registers
	logic [7:0]  own_id_q;
	logic [20:0] beat_period_q;
	logic [7:0]  hop_limit_q;

	// latched item
	logic        opcode_q;
	logic [7:0]  length_q;
	logic [7:0]  magic_q;
	logic        link_q;
	q_entry_t    item_q;

	// heartbeat state
	logic [15:0] next_seq_q;
	logic [31:0] last_beat_q;
	logic        sent_once_q;

	// output register
	logic        out_valid_q;
	q_entry_t    out_q;
	logic        out_own_q;

	seen_req_t   seen_req;
	seen_rsp_t   seen_rsp;
	logic        q_push;
	logic        q_pop;
	q_entry_t    q_wr_data;
	q_entry_t    q_rd_data;
	q_stat_t     q_stat;

	logic        in_xfer;
	logic        out_busy;
	logic        hdr_ok;
	logic        due;
	logic        beat_send;
	logic        beat_drop;
	logic        relay_send;
	logic        can_relay;
	logic        out_load_beat;
	logic        advance_seq;
	logic [31:0] elapsed;

	assign in_xfer = in_valid & ~in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_busy = out_valid_q & out_stall;
	assign cfg_ready = 1'b1;

	// tick decisions
	assign elapsed = item_q.time_word - last_beat_q;
	assign due = ~sent_once_q | (elapsed >= {11'd0, beat_period_q});
	assign beat_send = due & link_q;
	assign beat_drop = due & ~link_q;
	assign relay_send = ~due & link_q & ~q_stat.empty;

	// frame header filter
	assign hdr_ok = (length_q == FRAME_BYTES) && (magic_q == MAGIC_VALUE)
		&& (item_q.origin != own_id_q);
	assign can_relay = (({1'b0, item_q.hops} + 9'd1) <= {1'b0, hop_limit_q})
		&& ~q_stat.full;

	// control sequencer
	always_comb begin
		state_d = state_q;
		seen_req.scan = 1'b0;
		seen_req.record = 1'b0;
		seen_req.key = {item_q.origin, item_q.sequence_num};
		q_push = 1'b0;
		q_pop = 1'b0;
		out_load_beat = 1'b0;
		advance_seq = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (opcode_q == OP_FRAME) begin
					if (hdr_ok) begin
						seen_req.scan = 1'b1;
						state_d = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (beat_drop) begin
					advance_seq = 1'b1;
					state_d = ST_IDLE;
				end else if (beat_send) begin
					if (!out_busy) begin
						advance_seq = 1'b1;
						out_load_beat = 1'b1;
						seen_req.record = 1'b1;
						seen_req.key = {own_id_q, next_seq_q};
						state_d = ST_IDLE;
					end
				end else if (relay_send) begin
					if (!out_busy) begin
						q_pop = 1'b1;
						state_d = ST_POP;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (seen_rsp.done) begin
					if (!seen_rsp.hit) begin
						seen_req.record = 1'b1;
						q_push = can_relay;
					end
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// relayed copy carries one more hop
	always_comb begin
		q_wr_data = item_q;
		q_wr_data.hops = item_q.hops + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= OWN_ID_RST;
			beat_period_q <= BEAT_PERIOD_RST;
			hop_limit_q <= HOP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_ID: own_id_q <= cfg_data[7:0];
				CFG_BEAT_PERIOD: beat_period_q <= cfg_data;
				CFG_HOP_LIMIT: hop_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_q <= opcode;
			length_q <= frame_length;
			magic_q <= magic_byte;
			link_q <= link_ok;
			item_q.origin <= origin_node;
			item_q.hops <= hop_count;
			item_q.spare <= spare_byte;
			item_q.sequence_num <= sequence_req;
			item_q.time_word <= time_word;
			item_q.pos_x <= pos_x;
			item_q.pos_y <= pos_y;
			item_q.pos_z <= pos_z;
		end
	end

	// heartbeat sequence and timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			last_beat_q <= '0;
			sent_once_q <= 1'b0;
		end else begin
			if (advance_seq) begin
				next_seq_q <= next_seq_q + 16'd1;
			end
			if (out_load_beat) begin
				last_beat_q <= item_q.time_word;
				sent_once_q <= 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_beat || state_q == ST_POP) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load_beat) begin
			out_q.origin <= own_id_q;
			out_q.hops <= 8'd0;
			out_q.spare <= 8'd0;
			out_q.sequence_num <= next_seq_q;
			out_q.time_word <= item_q.time_word;
			out_q.pos_x <= item_q.pos_x;
			out_q.pos_y <= item_q.pos_y;
			out_q.pos_z <= item_q.pos_z;
			out_own_q <= 1'b1;
		end else if (state_q == ST_POP) begin
			out_q <= q_rd_data;
			out_own_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_magic = MAGIC_VALUE;
	assign out_origin = out_q.origin;
	assign out_hops = out_q.hops;
	assign out_spare = out_q.spare;
	assign out_sequence = out_q.sequence_num;
	assign out_time = out_q.time_word;
	assign out_pos_x = out_q.pos_x;
	assign out_pos_y = out_q.pos_y;
	assign out_pos_z = out_q.pos_z;
	assign out_is_own = out_own_q;

	hfr_seen #(
		.SEEN_DEPTH(SEEN_DEPTH)
	) u_seen (
		.clk(clk),
		.arst_n(arst_n),
		.req(seen_req),
		.rsp(seen_rsp)
	);

	hfr_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_data(q_wr_data),
		.pop(q_pop),
		.rd_data(q_rd_data),
		.stat(q_stat)
	);

endmodule

>>> src/hfr_seen.sv
// hfr_seen: ring of recently seen origin/sequence keys, scanned a row per cycle
// depends on hfr_pkg

module hfr_seen import hfr_pkg::*; #(
	parameter int SEEN_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  seen_req_t req,
	output seen_rsp_t rsp
);

	localparam int LANES = (SEEN_DEPTH >= 8) ? 8 : SEEN_DEPTH;
	localparam int ROWS = (SEEN_DEPTH + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int ENT_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);
	localparam logic [ENT_W-1:0] LAST_ENT = ENT_W'(SEEN_DEPTH - 1);

	logic [LANES-1:0][KEY_W-1:0] mem [ROWS];
	logic [LANES-1:0][KEY_W-1:0] row_s1;
	logic [LANES-1:0]            vld_s1;
	logic [LANES-1:0]            row_vld;
	logic [SEEN_DEPTH-1:0]       valid_q;
	logic [ENT_W-1:0]            wr_ptr_q;
	logic [ROW_W-1:0]            wr_row_q;
	logic [LANE_W-1:0]           wr_lane_q;
	logic [ROW_W-1:0]            rd_row_q;
	logic                        issuing_q;
	logic                        cmp_s1;
	logic                        last_s1;
	logic [KEY_W-1:0]            key_q;
	logic                        hit_now;

	// valid bits of the row being read
	always_comb begin
		int idx;
		row_vld = '0;
		for (int l = 0; l < LANES; l++) begin
			idx = int'(rd_row_q) * LANES + l;
			if (idx < SEEN_DEPTH) begin
				row_vld[l] = valid_q[ENT_W'(idx)];
			end
		end
	end

	// compare the registered row against the key
	always_comb begin
		hit_now = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			if (vld_s1[l] && row_s1[l] == key_q) begin
				hit_now = 1'b1;
			end
		end
		hit_now = hit_now & cmp_s1;
	end

	assign rsp.hit = hit_now;
	assign rsp.done = cmp_s1 & (hit_now | last_s1);

	// scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			rd_row_q <= '0;
			cmp_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			cmp_s1 <= issuing_q & ~rsp.done;
			last_s1 <= (rd_row_q == LAST_ROW);
			if (req.scan) begin
				issuing_q <= 1'b1;
				rd_row_q <= '0;
			end else if (rsp.done) begin
				issuing_q <= 1'b0;
			end else if (issuing_q) begin
				if (rd_row_q == LAST_ROW) begin
					issuing_q <= 1'b0;
				end else begin
					rd_row_q <= rd_row_q + ROW_W'(1);
				end
			end
		end
	end

	// search key
	always_ff @(posedge clk) begin
		if (req.scan) begin
			key_q <= req.key;
		end
	end

	// write pointer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			wr_ptr_q <= '0;
			wr_row_q <= '0;
			wr_lane_q <= '0;
		end else if (req.record) begin
			valid_q[wr_ptr_q] <= 1'b1;
			if (wr_ptr_q == LAST_ENT) begin
				wr_ptr_q <= '0;
				wr_row_q <= '0;
				wr_lane_q <= '0;
			end else begin
				wr_ptr_q <= wr_ptr_q + ENT_W'(1);
				if (wr_lane_q == LAST_LANE) begin
					wr_lane_q <= '0;
					wr_row_q <= wr_row_q + ROW_W'(1);
				end else begin
					wr_lane_q <= wr_lane_q + LANE_W'(1);
				end
			end
		end
	end

	// key memory, one lane written per record
	always_ff @(posedge clk) begin
		if (req.record) begin
			for (int l = 0; l < LANES; l++) begin
				if (LANE_W'(l) == wr_lane_q) begin
					mem[wr_row_q][l] <= req.key;
				end
			end
		end
		row_s1 <= mem[rd_row_q];
		vld_s1 <= row_vld;
	end

endmodule

>>> src/hfr_queue.sv
// hfr_queue: relay queue of frames waiting for a send opportunity
// depends on hfr_pkg

module hfr_queue import hfr_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_data,
	input  logic     pop,
	output q_entry_t rd_data,
	output q_stat_t  stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(QUEUE_DEPTH);

	q_entry_t         mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign stat.empty = (level_q == '0);
	assign stat.full = (level_q == FULL_LVL);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
				level_q <= level_q + LVL_W'(1);
			end else if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	// entry memory with registered read
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		rd_data <= mem[rd_ptr_q];
	end

endmodule

>>> src/hfr_checker.sv
// hfr_checker: port-level checks for heartbeat_flood_relay, bound to the top level
// depends on hfr_pkg and heartbeat_flood_relay

module hfr_checker import hfr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_magic,
	input logic [7:0]  out_hops,
	input logic [7:0]  out_spare,
	input logic        out_is_own
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// an accepted item keeps the input stalled on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in progress");

	// every sent frame carries the magic byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_magic == MAGIC_VALUE)
		else $error("sent frame without magic byte");

	// own heartbeat goes out with zero hops and zero spare
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_own |-> out_hops == 8'd0 && out_spare == 8'd0)
		else $error("own heartbeat with nonzero hops or spare");

endmodule

bind heartbeat_flood_relay hfr_checker u_hfr_checker (.*);

>>> tb/tb_heartbeat_flood_relay.sv
// tb_heartbeat_flood_relay: self-checking testbench for the heartbeat flood relay
// drives frames and ticks with random gaps and stalls and compares sent frames
// against a behavioral predictor; depends on hfr_pkg and heartbeat_flood_relay

module tb_heartbeat_flood_relay;
	import hfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEEN_N = 256;
	localparam int QUEUE_N = 32;
	localparam int STALL_LIMIT = 20000;

	// one item on the input channel
	typedef struct {
		logic        op;
		logic [7:0]  len;
		logic [7:0]  magic;
		logic [7:0]  origin;
		logic [7:0]  hops;
		logic [7:0]  spare;
		logic [15:0] seq;
		logic [31:0] tw;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        link;
	} relay_item_t;

	// one frame on the result channel
	typedef struct {
		logic [7:0]  magic;
		logic [7:0]  origin;
		logic [7:0]  hops;
		logic [7:0]  spare;
		logic [15:0] seq;
		logic [31:0] tw;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        own;
	} sent_frame_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic opcode;
	logic [7:0] frame_length, magic_byte, origin_node, hop_count, spare_byte;
	logic [15:0] sequence_req;
	logic [31:0] time_word, pos_x, pos_y, pos_z;
	logic link_ok;
	logic out_valid, out_stall;
	logic [7:0] out_magic, out_origin, out_hops, out_spare;
	logic [15:0] out_sequence;
	logic [31:0] out_time, out_pos_x, out_pos_y, out_pos_z;
	logic out_is_own;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	heartbeat_flood_relay u_dut (.*);

	// predictor state
	logic [7:0]  mdl_own_id;
	logic [20:0] mdl_period;
	logic [7:0]  mdl_hop_limit;
	logic [23:0] seen_key [SEEN_N];
	logic        seen_ok [SEEN_N];
	int          seen_wp;
	sent_frame_t relay_fifo [$];
	logic [15:0] beat_seq;
	logic [31:0] beat_last;
	logic        beat_once;

	sent_frame_t expected_frames [$];
	int          errors;
	int          idle_cycles;
	int          hold_cycles;
	logic        rx_random;
	logic [31:0] now_t;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on transfer activity
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	function automatic logic seen_has(input logic [23:0] k);
		for (int i = 0; i < SEEN_N; i++)
			if (seen_ok[i] && seen_key[i] == k) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void seen_add(input logic [23:0] k);
		seen_key[seen_wp] = k;
		seen_ok[seen_wp] = 1'b1;
		seen_wp = (seen_wp + 1) % SEEN_N;
	endfunction

	// predict the frame sent for one accepted item
	function automatic void predict_relay(input relay_item_t it);
		sent_frame_t f;
		logic [23:0] k;
		logic [8:0] nh;
		if (it.op == OP_FRAME) begin
			if (it.len != FRAME_BYTES || it.magic != MAGIC_VALUE || it.origin == mdl_own_id)
				return;
			k = {it.origin, it.seq};
			if (seen_has(k)) return;
			seen_add(k);
			nh = {1'b0, it.hops} + 9'd1;
			if (nh <= {1'b0, mdl_hop_limit} && relay_fifo.size() < QUEUE_N) begin
				f = '{MAGIC_VALUE, it.origin, nh[7:0], it.spare, it.seq,
					it.tw, it.px, it.py, it.pz, 1'b0};
				relay_fifo.push_back(f);
			end
			return;
		end
		if (!beat_once || (it.tw - beat_last) >= {11'd0, mdl_period}) begin
			f = '{MAGIC_VALUE, mdl_own_id, 8'd0, 8'd0, beat_seq,
				it.tw, it.px, it.py, it.pz, 1'b1};
			beat_seq++;
			if (!it.link) return;
			beat_last = it.tw;
			beat_once = 1'b1;
			seen_add({mdl_own_id, f.seq});
			expected_frames.push_back(f);
			return;
		end
		if (relay_fifo.size() > 0 && it.link)
			expected_frames.push_back(relay_fifo.pop_front());
	endfunction

	// receiver: random stall per transfer, or a forced hold
	initial begin
		int w;
		out_stall = 1'b1;
		hold_cycles = 0;
		rx_random = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (!rx_random) begin
				out_stall <= 1'b0;
			end else begin
				w = $urandom_range(0, 19);
				if ($urandom_range(0, 3) == 0) w = 0;
				if (w == 0) out_stall <= 1'b0;
				else begin
					out_stall <= 1'b1;
					repeat (w - 1) @(negedge clk);
					out_stall <= 1'b0;
				end
				@(posedge clk);
				while (!out_valid) @(posedge clk);
			end
		end
	end

	// compare each sent frame with the oldest expectation
	always @(posedge clk) begin
		sent_frame_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				errors++;
				$display("unexpected frame at %0t", $realtime);
			end else begin
				e = expected_frames.pop_front();
				if (out_magic != e.magic) report("magic", out_magic, e.magic);
				if (out_origin != e.origin) report("origin", out_origin, e.origin);
				if (out_hops != e.hops) report("hops", out_hops, e.hops);
				if (out_spare != e.spare) report("spare", out_spare, e.spare);
				if (out_sequence != e.seq) report("sequence", out_sequence, e.seq);
				if (out_time != e.tw) report("time", out_time, e.tw);
				if (out_pos_x != e.px) report("pos_x", out_pos_x, e.px);
				if (out_pos_y != e.py) report("pos_y", out_pos_y, e.py);
				if (out_pos_z != e.pz) report("pos_z", out_pos_z, e.pz);
				if (out_is_own != e.own) report("is_own", out_is_own, e.own);
			end
		end
	end

	// send one item after a gap, hold until transfer
	// valid drops for at least the cycle after a transfer, when the block stalls anyway
	task automatic send_item(input relay_item_t it, input logic gaps = 1'b1);
		int w;
		w = gaps ? $urandom_range(0, 19) : 0;
		if (gaps && $urandom_range(0, 3) == 0) w = 0;
		repeat (w + 1) @(negedge clk);
		in_valid <= 1'b1;
		opcode <= it.op;
		frame_length <= it.len;
		magic_byte <= it.magic;
		origin_node <= it.origin;
		hop_count <= it.hops;
		spare_byte <= it.spare;
		sequence_req <= it.seq;
		time_word <= it.tw;
		pos_x <= it.px;
		pos_y <= it.py;
		pos_z <= it.pz;
		link_ok <= it.link;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_relay(it);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_frames.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [20:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_OWN_ID: mdl_own_id = val[7:0];
			CFG_BEAT_PERIOD: mdl_period = val;
			CFG_HOP_LIMIT: mdl_hop_limit = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic relay_item_t good_frame(input logic [7:0] org, input logic [15:0] sq);
		relay_item_t it;
		it = '{OP_FRAME, FRAME_BYTES, MAGIC_VALUE, org, 8'($urandom_range(0, 5)),
			8'($urandom), sq, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
		return it;
	endfunction

	function automatic relay_item_t tick(input logic [31:0] t, input logic lk);
		relay_item_t it;
		it = '{OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 16'($urandom), t, $urandom, $urandom, $urandom, lk};
		return it;
	endfunction

	// directed: filters, duplicates, hop edges, refused heartbeat
	task automatic test_directed();
		relay_item_t it;
		send_item(tick(32'd0, 1'b0));           // first beat refused, seq still moves
		send_item(tick(32'd3, 1'b1));           // first beat sent
		it = good_frame(8'd9, 16'hFFFF);
		send_item(it);
		send_item(it);                          // duplicate dropped
		it.len = 8'd21; it.seq = 16'd1; send_item(it);
		it.len = FRAME_BYTES; it.magic = 8'hA6; send_item(it);
		it = good_frame(8'd0, 16'd5); send_item(it);   // own origin
		it = good_frame(8'hFF, 16'd0); it.hops = 8'hFF; send_item(it);
		it = good_frame(8'd7, 16'd2); it.hops = 8'd3; send_item(it);  // at limit
		it = good_frame(8'd7, 16'd3); it.hops = 8'd4; send_item(it);  // over limit
		it = good_frame(8'd0, 16'd1); it.origin = 8'd1; send_item(it);
		send_item(tick(32'd10, 1'b1));
		send_item(tick(32'd11, 1'b0));
		send_item(tick(32'd12, 1'b1));
		send_item(tick(32'd13, 1'b1));          // fifo empty unless both random-hop frames were queued
		send_item(tick(32'd3 + 32'd512, 1'b1)); // period elapsed
		send_item(tick(32'hFFFF_FFFF, 1'b1));   // wrap difference
		it = good_frame(8'd0, 16'd0); it.link = 1'b1; send_item(it);
		// own key recorded as seen
		write_reg(CFG_OWN_ID, 21'd200);
		it = good_frame(8'd0, 16'd1); it.hops = 0; send_item(it);
		send_item(tick(32'd20, 1'b1));
	endtask

	// random traffic under one setting
	task automatic test_random(input int n, input logic [7:0] org_span);
		relay_item_t it;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 5) begin
				it = good_frame(8'($urandom_range(0, org_span)), 16'($urandom_range(0, 40)));
				if ($urandom_range(0, 9) == 0) it.hops = 8'($urandom);
				if ($urandom_range(0, 15) == 0) it.len = 8'($urandom);
				if ($urandom_range(0, 15) == 0) it.magic = 8'($urandom);
				if ($urandom_range(0, 15) == 0) it.seq = 16'($urandom);
				if ($urandom_range(0, 15) == 0) it.origin = mdl_own_id;
			end else begin
				now_t += $urandom_range(0, 40);
				if ($urandom_range(0, 31) == 0) now_t = $urandom;
				it = tick(now_t, $urandom_range(0, 5) != 0);
			end
			send_item(it);
		end
	endtask

	// fill the fifo, then send ticks while the receiver holds off, then pause until drained
	task automatic test_backpressure();
		relay_item_t it;
		for (int i = 0; i < 40; i++) begin
			it = good_frame(8'($urandom_range(1, 250)), 16'($urandom));
			it.hops = 8'd0;
			send_item(it, 1'b0);
		end
		// one time step for all ticks, so after one beat the queue is served
		hold_cycles = 400;
		now_t += 1;
		for (int i = 0; i < 45; i++) begin
			send_item(tick(now_t, 1'b1), 1'b0);
		end
		drain();
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		now_t = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_FRAME;
		frame_length = '0; magic_byte = '0; origin_node = '0; hop_count = '0;
		spare_byte = '0; sequence_req = '0; time_word = '0;
		pos_x = '0; pos_y = '0; pos_z = '0; link_ok = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_OWN_ID; cfg_data = '0;
		mdl_own_id = OWN_ID_RST;
		mdl_period = BEAT_PERIOD_RST;
		mdl_hop_limit = HOP_LIMIT_RST;
		for (int i = 0; i < SEEN_N; i++) begin
			seen_ok[i] = 1'b0;
			seen_key[i] = '0;
		end
		seen_wp = 0;
		beat_seq = 0; beat_last = 0; beat_once = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_reg(CFG_BEAT_PERIOD, 21'd100);
		write_reg(CFG_HOP_LIMIT, 21'd255);
		test_random(150, 8'd20);
		write_reg(CFG_BEAT_PERIOD, 21'h1FFFFF);
		write_reg(CFG_HOP_LIMIT, 21'd0);
		write_reg(CFG_OWN_ID, 21'd255);
		test_random(80, 8'd255);
		write_reg(CFG_HOP_LIMIT, 21'd6);
		write_reg(CFG_BEAT_PERIOD, 21'd0);
		test_random(60, 8'd10);
		write_reg(CFG_BEAT_PERIOD, 21'd1);
		write_reg(CFG_OWN_ID, 21'd3);
		test_backpressure();
		write_reg(CFG_BEAT_PERIOD, 21'd300);
		write_reg(CFG_HOP_LIMIT, 21'd5);
		test_random(260, 8'd6);

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
